// ===== design/bpa_pkg.sv =====
package bpa_pkg;

    // Default geometry
    localparam int PAGE_COUNT_DEF = 1024;
    localparam int TOP_ORDER_DEF  = 10;
    localparam int PAGE_SHIFT     = 12;

    // Field widths
    localparam int OP_W     = 2;
    localparam int BYTES_W  = 32;
    localparam int ADDR_W   = 32;
    localparam int SORD_W   = 4;
    localparam int STATUS_W = 3;
    localparam int RORD_W   = 4;
    localparam int FREE_W   = 11;
    localparam int MANAGED_W = 11;

    localparam int S_DATA_W = 72;
    localparam int M_DATA_W = 48;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    // Operation codes
    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
    localparam logic [OP_W-1:0] OP_SEED  = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NO_MEM    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_UNALIGNED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BOUNDS    = 3'd4;

    // Register index of managed_pages
    localparam logic REG_MANAGED = 1'b0;

    localparam logic [MANAGED_W-1:0] MANAGED_RESET = 11'd1024;

endpackage

// ===== design/buddy_page_allocator.sv =====
// Buddy page allocator over 4 KiB pages, one free list per order.
// Requests enter on the s_ group: s_tuser carries the operation (allocate,
// free, seed), s_tdata the byte size, block address and seed order.
// Each request gives exactly one result on the m_ group: m_tuser carries
// the status, m_tdata the granted address, result order and free page count.
// managed_pages is written through the APB port at byte address 0; write it
// only while no request is in flight.
// The block works on one request at a time and drops s_tready meanwhile.
// A request is decoded in S_IDLE and handed off through S_DONE. A list
// unlink reads both links (S_RMRD) and writes them (S_RMWR); a split step
// passes S_SPLIT, S_INS and S_INS2, a merge step S_FLOOP, S_FCHK, S_RMRD
// and S_RMWR. Page metadata is written one page per cycle: splitting an
// order-n block to order 0 marks 2^n pages. The worst case is a free that
// merges TOP_ORDER times; the single metadata write port makes page marking
// the largest part of it. After reset the block sweeps the metadata memory
// once and accepts no request until done; APB writes are taken throughout.
// The result sits in an output register; a stalled receiver holds it and
// the next request may be taken, but its result waits until the register
// drains.
module buddy_page_allocator
    import bpa_pkg::*;
#(
    parameter int PAGE_COUNT = PAGE_COUNT_DEF,
    parameter int TOP_ORDER  = TOP_ORDER_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [31:0] request_bytes, [63:32] block_address, [67:64] seed_order
    input  logic [S_DATA_W-1:0]  s_tdata,
    // [1:0] op
    input  logic [OP_W-1:0]      s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [31:0] granted_address, [35:32] result_order, [46:36] free_pages
    output logic [M_DATA_W-1:0]  m_tdata,
    // [2:0] status
    output logic [STATUS_W-1:0]  m_tuser,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready
);

    localparam int IDXW = $clog2(PAGE_COUNT);
    localparam int LNKW = IDXW + 1;
    localparam int OW   = $clog2(TOP_ORDER + 1);
    localparam int NW   = (LNKW > TOP_ORDER + 1) ? LNKW : TOP_ORDER + 1;
    localparam int PW   = NW + 1;
    localparam int CNTW = $clog2(PAGE_COUNT + 1);
    localparam int SW   = ((CNTW > TOP_ORDER + 1) ? CNTW : TOP_ORDER + 1) + 1;
    localparam int MW   = TOP_ORDER + 1;
    localparam logic [LNKW-1:0] NIL = LNKW'(PAGE_COUNT);

    typedef enum logic [13:0] {
        S_CLEAR = 14'b00000000000001,
        S_IDLE  = 14'b00000000000010,
        S_AFIND = 14'b00000000000100,
        S_RMRD  = 14'b00000000001000,
        S_RMWR  = 14'b00000000010000,
        S_SPLIT = 14'b00000000100000,
        S_INS   = 14'b00000001000000,
        S_INS2  = 14'b00000010000000,
        S_MARK  = 14'b00000100000000,
        S_FRD   = 14'b00001000000000,
        S_FORD  = 14'b00010000000000,
        S_FLOOP = 14'b00100000000000,
        S_FCHK  = 14'b01000000000000,
        S_DONE  = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;

    logic [MANAGED_W-1:0] managed_reg;
    logic [LNKW-1:0] head_reg [TOP_ORDER+1];
    logic [LNKW-1:0] head_next [TOP_ORDER+1];

    logic [OW-1:0]   ord_reg, ord_next;
    logic [OW-1:0]   cur_reg, cur_next;
    logic [OW-1:0]   orig_reg, orig_next;
    logic [NW-1:0]   blk_reg, blk_next;
    logic [NW-1:0]   rm_node_reg, rm_node_next;
    logic [OW-1:0]   rm_ord_reg, rm_ord_next;
    logic            rm_free_reg, rm_free_next;
    logic [NW-1:0]   ins_node_reg, ins_node_next;
    logic [OW-1:0]   ins_ord_reg, ins_ord_next;
    logic [LNKW-1:0] ins_head_reg, ins_head_next;
    logic [NW-1:0]   mk_start_reg, mk_start_next;
    logic [OW-1:0]   mk_ord_reg, mk_ord_next;
    logic            mk_free_reg, mk_free_next;
    logic [MW-1:0]   mk_cnt_reg, mk_cnt_next;
    logic            split_ret_reg, split_ret_next;
    logic [CNTW-1:0] fcnt_reg, fcnt_next;
    logic [IDXW-1:0] clr_reg, clr_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [OW-1:0]   rord_reg, rord_next;
    logic [ADDR_W-1:0] grant_reg, grant_next;

    logic                ov_reg, ov_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [ADDR_W-1:0]   out_grant_reg, out_grant_next;
    logic [RORD_W-1:0]   out_ord_reg, out_ord_next;
    logic [FREE_W-1:0]   out_fp_reg, out_fp_next;

    // Metadata memory: {free flag, order}
    logic            meta_we;
    logic [IDXW-1:0] meta_waddr, meta_raddr;
    logic [OW:0]     meta_wdata, meta_rdata;
    logic            nxt_we, prv_we;
    logic [IDXW-1:0] nxt_waddr, prv_waddr, link_raddr;
    logic [LNKW-1:0] nxt_wdata, prv_wdata, nxt_rdata, prv_rdata;

    bpa_ram #(.WIDTH(OW + 1), .DEPTH(PAGE_COUNT)) u_meta (
        .clk(clk), .wr_en(meta_we), .wr_addr(meta_waddr), .wr_data(meta_wdata),
        .rd_addr(meta_raddr), .rd_data(meta_rdata)
    );

    bpa_ram #(.WIDTH(LNKW), .DEPTH(PAGE_COUNT)) u_next (
        .clk(clk), .wr_en(nxt_we), .wr_addr(nxt_waddr), .wr_data(nxt_wdata),
        .rd_addr(link_raddr), .rd_data(nxt_rdata)
    );

    bpa_ram #(.WIDTH(LNKW), .DEPTH(PAGE_COUNT)) u_prev (
        .clk(clk), .wr_en(prv_we), .wr_addr(prv_waddr), .wr_data(prv_wdata),
        .rd_addr(link_raddr), .rd_data(prv_rdata)
    );

    // Request fields
    logic [BYTES_W-1:0] in_bytes;
    logic [ADDR_W-1:0]  in_addr;
    logic [SORD_W-1:0]  in_sord;
    assign in_bytes = s_tdata[31:0];
    assign in_addr  = s_tdata[63:32];
    assign in_sord  = s_tdata[67:64];

    // Effective bound: min(managed_pages, PAGE_COUNT)
    logic [31:0] lim;
    assign lim = (32'(managed_reg) < 32'(PAGE_COUNT)) ? 32'(managed_reg) : 32'(PAGE_COUNT);

    // Allocation order: bit length of (bytes - 1) >> PAGE_SHIFT
    logic [BYTES_W-1:0] pm1;
    logic [5:0]         req_ord;
    always_comb
    begin
        pm1 = ((in_bytes == '0) ? '0 : in_bytes - 32'd1) >> PAGE_SHIFT;
        req_ord = '0;
        for (int b = 0; b < 20; b++)
        begin
            if (pm1[b])
            begin
                req_ord = 6'(b + 1);
            end
        end
    end

    // Request checks for free and seed
    logic [31:0] in_idx;
    logic [31:0] seed_mask;
    logic [32:0] seed_end;
    assign in_idx    = in_addr >> PAGE_SHIFT;
    assign seed_mask = (32'd1 << (PAGE_SHIFT + 32'(in_sord))) - 32'd1;
    assign seed_end  = 33'(in_idx) + (33'd1 << in_sord);

    logic accept;
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    // Mark addressing
    logic [PW-1:0] mk_page;
    logic [MW-1:0] mk_last;
    assign mk_page = PW'(mk_start_reg) + PW'(mk_cnt_reg);
    assign mk_last = (MW'(1) << mk_ord_reg) - MW'(1);

    // Buddy helpers
    logic [NW-1:0] split_bud;
    logic [NW-1:0] free_bud;
    assign split_bud = blk_reg ^ (NW'(1) << (cur_reg - OW'(1)));
    assign free_bud  = blk_reg ^ (NW'(1) << ord_reg);

    // Link values read for an unlink
    logic [LNKW-1:0] rm_nx, rm_pv;
    assign rm_nx = (nxt_rdata >= NIL) ? NIL : nxt_rdata;
    assign rm_pv = (prv_rdata >= NIL) ? NIL : prv_rdata;

    // Count arithmetic
    logic [SW-1:0] cnt_sum;
    logic [SW-1:0] add_n;
    logic [SW-1:0] sub_n;
    always_comb
    begin
        add_n   = SW'(1) << ((state_reg == S_IDLE) ? OW'(in_sord) : orig_reg);
        sub_n   = SW'(1) << ord_reg;
        cnt_sum = SW'(fcnt_reg) + add_n;
    end

    logic          found;
    logic [OW-1:0] found_ord;
    logic [OW-1:0] meta_ord;

    always_comb
    begin
        state_next      = state_reg;
        ord_next        = ord_reg;
        cur_next        = cur_reg;
        orig_next       = orig_reg;
        blk_next        = blk_reg;
        rm_node_next    = rm_node_reg;
        rm_ord_next     = rm_ord_reg;
        rm_free_next    = rm_free_reg;
        ins_node_next   = ins_node_reg;
        ins_ord_next    = ins_ord_reg;
        ins_head_next   = ins_head_reg;
        mk_start_next   = mk_start_reg;
        mk_ord_next     = mk_ord_reg;
        mk_free_next    = mk_free_reg;
        mk_cnt_next     = mk_cnt_reg;
        split_ret_next  = split_ret_reg;
        fcnt_next       = fcnt_reg;
        clr_next        = clr_reg;
        status_next     = status_reg;
        rord_next       = rord_reg;
        grant_next      = grant_reg;
        for (int k = 0; k <= TOP_ORDER; k++)
        begin
            head_next[k] = head_reg[k];
        end

        meta_we    = 1'b0;
        meta_waddr = IDXW'(mk_page);
        meta_wdata = {mk_free_reg, mk_ord_reg};
        meta_raddr = IDXW'(blk_reg);
        nxt_we     = 1'b0;
        nxt_waddr  = IDXW'(ins_node_reg);
        nxt_wdata  = head_reg[ins_ord_reg];
        prv_we     = 1'b0;
        prv_waddr  = IDXW'(ins_node_reg);
        prv_wdata  = NIL;
        link_raddr = IDXW'(rm_node_reg);

        found     = 1'b0;
        found_ord = '0;
        for (int k = 0; k <= TOP_ORDER; k++)
        begin
            if (!found && OW'(k) >= ord_reg && head_reg[k] < NIL)
            begin
                found     = 1'b1;
                found_ord = OW'(k);
            end
        end

        meta_ord = (meta_rdata[OW-1:0] > OW'(TOP_ORDER)) ? OW'(TOP_ORDER)
                                                         : meta_rdata[OW-1:0];

        ov_next         = ov_reg && !m_tready;
        out_status_next = out_status_reg;
        out_grant_next  = out_grant_reg;
        out_ord_next    = out_ord_reg;
        out_fp_next     = out_fp_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                meta_we    = 1'b1;
                meta_waddr = clr_reg;
                meta_wdata = '0;
                clr_next   = clr_reg + IDXW'(1);
                if (clr_reg == IDXW'(PAGE_COUNT - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    status_next = ST_OK;
                    rord_next   = '0;
                    grant_next  = '0;
                    state_next  = S_DONE;
                    unique case (s_tuser)
                        OP_ALLOC:
                        begin
                            if (req_ord > 6'(TOP_ORDER))
                            begin
                                status_next = ST_TOO_LARGE;
                            end
                            else
                            begin
                                ord_next   = OW'(req_ord);
                                state_next = S_AFIND;
                            end
                        end
                        OP_FREE:
                        begin
                            if (in_addr == '0)
                            begin
                                status_next = ST_OK;
                            end
                            else if (in_addr[PAGE_SHIFT-1:0] != '0)
                            begin
                                status_next = ST_UNALIGNED;
                            end
                            else if (in_idx >= lim)
                            begin
                                status_next = ST_BOUNDS;
                            end
                            else
                            begin
                                blk_next   = NW'(in_idx);
                                state_next = S_FRD;
                            end
                        end
                        OP_SEED:
                        begin
                            if (32'(in_sord) > 32'(TOP_ORDER))
                            begin
                                status_next = ST_TOO_LARGE;
                            end
                            else if ((in_addr & seed_mask) != '0)
                            begin
                                status_next = ST_UNALIGNED;
                            end
                            else if (seed_end > 33'(lim))
                            begin
                                status_next = ST_BOUNDS;
                            end
                            else
                            begin
                                ins_node_next  = NW'(in_idx);
                                ins_ord_next   = OW'(in_sord);
                                split_ret_next = 1'b0;
                                rord_next      = OW'(in_sord);
                                fcnt_next      = (cnt_sum > SW'(PAGE_COUNT))
                                                 ? CNTW'(PAGE_COUNT) : CNTW'(cnt_sum);
                                state_next     = S_INS;
                            end
                        end
                        default:
                        begin
                            status_next = ST_OK;
                        end
                    endcase
                end
            end
            S_AFIND:
            begin
                if (!found)
                begin
                    status_next = ST_NO_MEM;
                    state_next  = S_DONE;
                end
                else
                begin
                    cur_next     = found_ord;
                    blk_next     = NW'(head_reg[found_ord]);
                    rm_node_next = NW'(head_reg[found_ord]);
                    rm_ord_next  = found_ord;
                    rm_free_next = 1'b0;
                    state_next   = S_RMRD;
                end
            end
            S_RMRD:
            begin
                // read both links of the node being unlinked
                state_next = S_RMWR;
            end
            S_RMWR:
            begin
                if (rm_pv == NIL)
                begin
                    head_next[rm_ord_reg] = rm_nx;
                end
                else
                begin
                    nxt_we    = 1'b1;
                    nxt_waddr = IDXW'(rm_pv);
                    nxt_wdata = rm_nx;
                end
                if (rm_nx != NIL)
                begin
                    prv_we    = 1'b1;
                    prv_waddr = IDXW'(rm_nx);
                    prv_wdata = rm_pv;
                end
                if (rm_free_reg)
                begin
                    if (rm_node_reg < blk_reg)
                    begin
                        blk_next = rm_node_reg;
                    end
                    ord_next   = ord_reg + OW'(1);
                    state_next = S_FLOOP;
                end
                else
                begin
                    state_next = S_SPLIT;
                end
            end
            S_SPLIT:
            begin
                if (cur_reg > ord_reg)
                begin
                    cur_next       = cur_reg - OW'(1);
                    ins_node_next  = split_bud;
                    ins_ord_next   = cur_reg - OW'(1);
                    split_ret_next = 1'b1;
                    state_next     = S_INS;
                end
                else
                begin
                    mk_start_next  = blk_reg;
                    mk_ord_next    = ord_reg;
                    mk_free_next   = 1'b0;
                    mk_cnt_next    = '0;
                    split_ret_next = 1'b0;
                    fcnt_next      = (SW'(fcnt_reg) >= sub_n)
                                     ? CNTW'(SW'(fcnt_reg) - sub_n) : '0;
                    grant_next     = ADDR_W'(blk_reg) << PAGE_SHIFT;
                    rord_next      = ord_reg;
                    state_next     = S_MARK;
                end
            end
            S_INS:
            begin
                if (ins_node_reg >= NW'(PAGE_COUNT))
                begin
                    state_next = split_ret_reg ? S_SPLIT : S_DONE;
                end
                else
                begin
                    nxt_we                 = 1'b1;
                    prv_we                 = 1'b1;
                    ins_head_next          = head_reg[ins_ord_reg];
                    head_next[ins_ord_reg] = LNKW'(ins_node_reg);
                    state_next             = S_INS2;
                end
            end
            S_INS2:
            begin
                if (ins_head_reg < NIL)
                begin
                    prv_we    = 1'b1;
                    prv_waddr = IDXW'(ins_head_reg);
                    prv_wdata = LNKW'(ins_node_reg);
                end
                mk_start_next = ins_node_reg;
                mk_ord_next   = ins_ord_reg;
                mk_free_next  = 1'b1;
                mk_cnt_next   = '0;
                state_next    = S_MARK;
            end
            S_MARK:
            begin
                // one page of metadata per cycle
                meta_we     = (mk_page < PW'(PAGE_COUNT));
                mk_cnt_next = mk_cnt_reg + MW'(1);
                if (mk_cnt_reg == mk_last)
                begin
                    state_next = split_ret_reg ? S_SPLIT : S_DONE;
                end
            end
            S_FRD:
            begin
                meta_raddr = IDXW'(blk_reg);
                state_next = S_FORD;
            end
            S_FORD:
            begin
                ord_next   = meta_ord;
                orig_next  = meta_ord;
                state_next = S_FLOOP;
            end
            S_FLOOP:
            begin
                meta_raddr = IDXW'(free_bud);
                if (ord_reg < OW'(TOP_ORDER) && 32'(free_bud) < lim)
                begin
                    state_next = S_FCHK;
                end
                else
                begin
                    ins_node_next  = blk_reg;
                    ins_ord_next   = ord_reg;
                    split_ret_next = 1'b0;
                    rord_next      = ord_reg;
                    fcnt_next      = (cnt_sum > SW'(PAGE_COUNT))
                                     ? CNTW'(PAGE_COUNT) : CNTW'(cnt_sum);
                    state_next     = S_INS;
                end
            end
            S_FCHK:
            begin
                if (meta_rdata[OW] && meta_rdata[OW-1:0] == ord_reg)
                begin
                    rm_node_next = free_bud;
                    rm_ord_next  = ord_reg;
                    rm_free_next = 1'b1;
                    state_next   = S_RMRD;
                end
                else
                begin
                    ins_node_next  = blk_reg;
                    ins_ord_next   = ord_reg;
                    split_ret_next = 1'b0;
                    rord_next      = ord_reg;
                    fcnt_next      = (cnt_sum > SW'(PAGE_COUNT))
                                     ? CNTW'(PAGE_COUNT) : CNTW'(cnt_sum);
                    state_next     = S_INS;
                end
            end
            S_DONE:
            begin
                // hold until the output register is free
                if (!ov_reg || m_tready)
                begin
                    ov_next         = 1'b1;
                    out_status_next = status_reg;
                    out_grant_next  = grant_reg;
                    out_ord_next    = RORD_W'(rord_reg);
                    out_fp_next     = FREE_W'(fcnt_reg);
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            managed_reg <= MANAGED_RESET;
            fcnt_reg    <= '0;
            clr_reg     <= '0;
            ov_reg      <= 1'b0;
            for (int k = 0; k <= TOP_ORDER; k++)
            begin
                head_reg[k] <= NIL;
            end
        end
        else
        begin
            state_reg <= state_next;
            fcnt_reg  <= fcnt_next;
            clr_reg   <= clr_next;
            ov_reg    <= ov_next;
            for (int k = 0; k <= TOP_ORDER; k++)
            begin
                head_reg[k] <= head_next[k];
            end
            if (psel && penable && pwrite && pready && paddr[2] == REG_MANAGED)
            begin
                managed_reg <= pwdata[MANAGED_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ord_reg        <= ord_next;
        cur_reg        <= cur_next;
        orig_reg       <= orig_next;
        blk_reg        <= blk_next;
        rm_node_reg    <= rm_node_next;
        rm_ord_reg     <= rm_ord_next;
        rm_free_reg    <= rm_free_next;
        ins_node_reg   <= ins_node_next;
        ins_ord_reg    <= ins_ord_next;
        ins_head_reg   <= ins_head_next;
        mk_start_reg   <= mk_start_next;
        mk_ord_reg     <= mk_ord_next;
        mk_free_reg    <= mk_free_next;
        mk_cnt_reg     <= mk_cnt_next;
        split_ret_reg  <= split_ret_next;
        status_reg     <= status_next;
        rord_reg       <= rord_next;
        grant_reg      <= grant_next;
        out_status_reg <= out_status_next;
        out_grant_reg  <= out_grant_next;
        out_ord_reg    <= out_ord_next;
        out_fp_reg     <= out_fp_next;
    end

    assign m_tvalid = ov_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {1'b0, out_fp_reg, out_ord_reg, out_grant_reg};

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MANAGED) ? PDATA_W'(managed_reg) : '0;

endmodule

// ===== design/bpa_ram.sv =====
module bpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sim/tb_buddy_page_allocator.sv =====
`timescale 1ns / 1ps

module tb_buddy_page_allocator;
    import bpa_pkg::*;

    localparam int NPAGES = PAGE_COUNT_DEF;
    localparam int TOPORD = TOP_ORDER_DEF;
    localparam logic [OP_W-1:0] OP_INVALID = 2'd3;
    localparam int ADDR_MANAGED = 0;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   granted;
        logic [RORD_W-1:0]   order;
        logic [FREE_W-1:0]   pages;
    } alloc_result_t;

    typedef struct {
        int unsigned addr;
        int          order;
    } held_block_t;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic [OP_W-1:0]     s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0] m_tuser;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    // Shadow copy of the allocator's page metadata and free lists
    bit          page_is_free [NPAGES];
    int          page_order   [NPAGES];
    int          link_next    [NPAGES];
    int          link_prev    [NPAGES];
    int          order_head   [TOPORD+1];
    int          free_count;
    int          managed_limit;

    // Pages ever given to the allocator by a seed; random seeds avoid them
    bit          page_seeded  [NPAGES];
    held_block_t held_blocks[$];
    alloc_result_t pending_results[$];

    int          failures;
    bit          no_gaps;
    int          stall_left;

    buddy_page_allocator DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop: far beyond the slowest legal run (about 350 requests,
    // plus stalls and the reset sweep).
    initial
    begin
        #15_000_000;
        $display("tb_buddy_page_allocator failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Allocator shadow model
    // ------------------------------------------------------------------
    function automatic int bound_pages();
        return (managed_limit < NPAGES) ? managed_limit : NPAGES;
    endfunction

    function automatic void mark_block(int start, int ord, bit is_free);
        int p;
        for (int i = 0; i < (1 << ord); i++)
        begin
            p = start + i;
            if (p < NPAGES)
            begin
                page_is_free[p] = is_free;
                page_order[p]   = ord;
            end
        end
    endfunction

    function automatic void push_free_block(int node, int ord);
        int h;
        if (node >= NPAGES || ord > TOPORD)
            return;
        h = order_head[ord];
        link_next[node] = h;
        link_prev[node] = NPAGES;
        if (h < NPAGES)
            link_prev[h] = node;
        order_head[ord] = node;
        mark_block(node, ord, 1'b1);
    endfunction

    function automatic void unlink_free_block(int node, int ord);
        int nx;
        int pv;
        if (node >= NPAGES || ord > TOPORD)
            return;
        nx = (link_next[node] >= NPAGES) ? NPAGES : link_next[node];
        pv = (link_prev[node] >= NPAGES) ? NPAGES : link_prev[node];
        if (pv == NPAGES)
            order_head[ord] = nx;
        else
            link_next[pv] = nx;
        if (nx != NPAGES)
            link_prev[nx] = pv;
    endfunction

    function automatic void add_free_pages(int n);
        free_count += n;
        if (free_count > NPAGES)
            free_count = NPAGES;
    endfunction

    function automatic alloc_result_t predict_allocator(logic [OP_W-1:0] op,
                                                        logic [31:0] bytes,
                                                        logic [31:0] addr,
                                                        logic [3:0] sord);
        alloc_result_t r;
        longint        npages;
        int            ord;
        int            cur;
        int            blk;
        int            idx;
        int            lim;
        int            orig;
        int            bud;
        r = '{default: '0};
        lim = bound_pages();
        case (op)
            OP_ALLOC:
            begin
                npages = ((bytes == 0 ? 64'd1 : longint'(bytes)) + 4095) >> PAGE_SHIFT;
                ord = 0;
                while (ord < 40 && (64'd1 << ord) < npages)
                    ord++;
                if (ord > TOPORD)
                    r.status = ST_TOO_LARGE;
                else
                begin
                    cur = ord;
                    while (cur <= TOPORD && order_head[cur] >= NPAGES)
                        cur++;
                    if (cur > TOPORD)
                        r.status = ST_NO_MEM;
                    else
                    begin
                        blk = order_head[cur];
                        unlink_free_block(blk, cur);
                        // split down, upper halves go back on their lists
                        while (cur > ord)
                        begin
                            cur--;
                            push_free_block(blk ^ (1 << cur), cur);
                        end
                        mark_block(blk, ord, 1'b0);
                        free_count = (free_count >= (1 << ord)) ? free_count - (1 << ord) : 0;
                        r.granted = ADDR_W'(blk << PAGE_SHIFT);
                        r.order = RORD_W'(ord);
                    end
                end
            end
            OP_FREE:
            begin
                if (addr != 0)
                begin
                    idx = addr >> PAGE_SHIFT;
                    if (addr[PAGE_SHIFT-1:0] != 0)
                        r.status = ST_UNALIGNED;
                    else if (idx >= lim)
                        r.status = ST_BOUNDS;
                    else
                    begin
                        ord = (page_order[idx] > TOPORD) ? TOPORD : page_order[idx];
                        orig = ord;
                        // coalesce while the buddy is free and the same size
                        while (ord < TOPORD)
                        begin
                            bud = idx ^ (1 << ord);
                            if (bud >= lim || !page_is_free[bud] || page_order[bud] != ord)
                                break;
                            unlink_free_block(bud, ord);
                            if (bud < idx)
                                idx = bud;
                            ord++;
                        end
                        push_free_block(idx, ord);
                        add_free_pages(1 << orig);
                        r.order = RORD_W'(ord);
                    end
                end
            end
            OP_SEED:
            begin
                if (sord > TOPORD)
                    r.status = ST_TOO_LARGE;
                else if ((addr & ((33'd1 << (PAGE_SHIFT + sord)) - 1)) != 0)
                    r.status = ST_UNALIGNED;
                else if (longint'(addr >> PAGE_SHIFT) + (64'd1 << sord) > lim)
                    r.status = ST_BOUNDS;
                else
                begin
                    push_free_block(addr >> PAGE_SHIFT, sord);
                    add_free_pages(1 << sord);
                    r.order = sord;
                end
            end
            default: ;
        endcase
        r.pages = FREE_W'(free_count);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Request driver
    // ------------------------------------------------------------------
    function automatic int draw_gap();
        return no_gaps ? 0 : $urandom_range(0, 5);
    endfunction

    // Send one request; tvalid stays high afterward so back-to-back
    // requests need no extra assignment in the same step.
    task automatic send_request(logic [OP_W-1:0] op, logic [31:0] bytes,
                                logic [31:0] addr, logic [3:0] sord);
        int            gap;
        alloc_result_t r;
        held_block_t   hb;
        gap = draw_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'b0, sord, addr, bytes};
        do
            @(posedge clk);
        while (!s_tready);
        r = predict_allocator(op, bytes, addr, sord);
        pending_results.push_back(r);
        if (r.status == ST_OK && op == OP_ALLOC)
        begin
            hb.addr = r.granted;
            hb.order = int'(r.order);
            held_blocks.push_back(hb);
        end
        if (r.status == ST_OK && op == OP_SEED)
            for (int i = 0; i < (1 << sord); i++)
                page_seeded[(addr >> PAGE_SHIFT) + i] = 1'b1;
    endtask

    // Drop tvalid and hold until every result is back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_managed(int value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(ADDR_MANAGED);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        managed_limit = value & 32'h7FF;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic bit region_fresh(int start, int ord);
        if (start + (1 << ord) > bound_pages())
            return 1'b0;
        for (int i = 0; i < (1 << ord); i++)
            if (page_seeded[start + i])
                return 1'b0;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Result checker with random backpressure
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        alloc_result_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result with no request outstanding");
                    failures++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (m_tuser !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, m_tuser);
                        failures++;
                    end
                    if (m_tdata[31:0] !== want.granted)
                    begin
                        $error("granted_address: expected %h, got %h",
                               want.granted, m_tdata[31:0]);
                        failures++;
                    end
                    if (m_tdata[35:32] !== want.order)
                    begin
                        $error("result_order: expected %0d, got %0d",
                               want.order, m_tdata[35:32]);
                        failures++;
                    end
                    if (m_tdata[46:36] !== want.pages)
                    begin
                        $error("free_pages: expected %0d, got %0d",
                               want.pages, m_tdata[46:36]);
                        failures++;
                    end
                end
                stall_left = draw_gap();
            end
            else if (stall_left > 0)
                stall_left--;
            m_tready <= (stall_left == 0);
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Empty allocator: every error path and the ignored cases
    task automatic test_empty_and_errors();
        send_request(OP_ALLOC, 32'd1, 32'd0, 4'd0);
        send_request(OP_ALLOC, 32'hFFFF_FFFF, 32'd0, 4'd0);
        send_request(OP_ALLOC, 32'h0040_0001, 32'd0, 4'd0);
        send_request(OP_ALLOC, 32'h0040_0000, 32'd0, 4'd0);
        send_request(OP_FREE, 32'd0, 32'd0, 4'd0);
        send_request(OP_FREE, 32'd0, 32'h0000_1FFF, 4'd0);
        send_request(OP_FREE, 32'd0, 32'hFFFF_F000, 4'd0);
        send_request(OP_FREE, 32'd0, NPAGES << PAGE_SHIFT, 4'd0);
        send_request(OP_SEED, 32'd0, 32'd0, 4'd11);
        send_request(OP_SEED, 32'd0, 32'd0, 4'd15);
        send_request(OP_SEED, 32'd0, 32'h0000_2000, 4'd2);
        send_request(OP_SEED, 32'd0, 1020 << PAGE_SHIFT, 4'd3);
        send_request(OP_INVALID, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF);
    endtask

    // Seed a 16-page block, split it, then free back to a full merge
    task automatic test_split_and_merge();
        send_request(OP_SEED, 32'd0, 512 << PAGE_SHIFT, 4'd4);
        send_request(OP_ALLOC, 32'd0, 32'd0, 4'd0);
        send_request(OP_ALLOC, 32'd4097, 32'd0, 4'd0);
        send_request(OP_FREE, 32'd0, 514 << PAGE_SHIFT, 4'd0);
        send_request(OP_FREE, 32'd0, 512 << PAGE_SHIFT, 4'd0);
        send_request(OP_SEED, 32'd0, 1023 << PAGE_SHIFT, 4'd0);
        send_request(OP_SEED, 32'd0, 32'd0, 4'd0);
        send_request(OP_ALLOC, 32'h0040_0000, 32'd0, 4'd0);
        send_request(OP_ALLOC, 32'd4096, 32'd0, 4'd0);
        drain_results();
        // the block at address zero cannot be freed, forget it
        held_blocks = {};
    endtask

    // Shrink the managed range to one page, then past the maximum
    task automatic test_managed_bound();
        write_managed(1);
        send_request(OP_SEED, 32'd0, 1 << PAGE_SHIFT, 4'd0);
        send_request(OP_FREE, 32'd0, 1 << PAGE_SHIFT, 4'd0);
        send_request(OP_FREE, 32'd0, 512 << PAGE_SHIFT, 4'd0);
        drain_results();
        write_managed(2047);
        send_request(OP_SEED, 32'd0, 1016 << PAGE_SHIFT, 4'd3);
        send_request(OP_ALLOC, 32'd32768, 32'd0, 4'd0);
        drain_results();
        write_managed(NPAGES);
    endtask

    task automatic random_alloc();
        logic [31:0] bytes;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            bytes = $urandom_range(0, 65536);
        else if (pick < 85)
            bytes = $urandom_range(0, 1 << 22);
        else
            bytes = $urandom;
        send_request(OP_ALLOC, bytes, $urandom, 4'($urandom));
    endtask

    task automatic random_free();
        int          pick;
        int          k;
        held_block_t hb;
        pick = $urandom_range(0, 99);
        if (held_blocks.size() != 0 && pick < 85)
        begin
            k = $urandom_range(0, held_blocks.size() - 1);
            hb = held_blocks[k];
            send_request(OP_FREE, $urandom, hb.addr, 4'($urandom));
            // out of bounds leaves the block held
            if (pending_results[$].status != ST_BOUNDS)
                held_blocks.delete(k);
        end
        else if (pick < 90)
            send_request(OP_FREE, $urandom, 32'd0, 4'($urandom));
        else if (pick < 95)
            send_request(OP_FREE, $urandom, $urandom | 32'h1, 4'($urandom));
        else
            send_request(OP_FREE, $urandom,
                         $urandom_range(NPAGES, (1 << 20) - 1) << PAGE_SHIFT,
                         4'($urandom));
    endtask

    task automatic random_seed();
        int ord;
        int start;
        int pick;
        bit found;
        found = 1'b0;
        pick = $urandom_range(0, 99);
        if (pick < 75)
        begin
            ord = ($urandom_range(0, 9) == 0) ? $urandom_range(7, TOPORD)
                                               : $urandom_range(0, 6);
            for (int t = 0; t < 8 && !found; t++)
            begin
                start = ($urandom_range(0, NPAGES - 1) >> ord) << ord;
                found = region_fresh(start, ord);
            end
        end
        if (found)
            send_request(OP_SEED, $urandom, start << PAGE_SHIFT, 4'(ord));
        else if (pick < 85)
            send_request(OP_SEED, $urandom, $urandom, 4'($urandom_range(TOPORD + 1, 15)));
        else if (pick < 93)
            send_request(OP_SEED, $urandom, $urandom | 32'h1, 4'($urandom_range(0, TOPORD)));
        else
            send_request(OP_SEED, $urandom,
                         $urandom_range(NPAGES, (1 << 20) - 1) << PAGE_SHIFT, 4'd0);
    endtask

    task automatic random_requests(int count);
        int pick;
        for (int n = 0; n < count; n++)
        begin
            no_gaps = (n % 60) >= 45;
            // wait for every result now and then
            if (n % 50 == 49)
                drain_results();
            pick = $urandom_range(0, 99);
            if (pick < 38)
                random_alloc();
            else if (pick < 70)
                random_free();
            else if (pick < 95)
                random_seed();
            else
                send_request(OP_INVALID, $urandom, $urandom, 4'($urandom));
        end
        no_gaps = 1'b0;
        drain_results();
    endtask

    task automatic test_random_traffic();
        random_requests(140);
        write_managed($urandom_range(1, NPAGES));
        random_requests(70);
        write_managed(NPAGES);
        random_requests(70);
    endtask

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = OP_ALLOC;
        m_tready = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        failures = 0;
        no_gaps  = 1'b0;
        stall_left = 0;
        for (int i = 0; i < NPAGES; i++)
        begin
            page_is_free[i] = 1'b0;
            page_order[i]   = 0;
            link_next[i]    = 0;
            link_prev[i]    = 0;
            page_seeded[i]  = 1'b0;
        end
        for (int i = 0; i <= TOPORD; i++)
            order_head[i] = NPAGES;
        free_count = 0;
        managed_limit = MANAGED_RESET;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_and_errors();
        test_split_and_merge();
        test_managed_bound();
        test_random_traffic();

        drain_results();
        // let any stray result show up
        repeat (1200) @(posedge clk);
        if (failures == 0)
            $display("tb_buddy_page_allocator passed");
        else
            $display("tb_buddy_page_allocator failed");
        $finish;
    end

endmodule
